// File: rtl/core/assert_macros.svh
// Assertion shorthands shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off while in reset.
`define FED_ASSERT_NOW(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// Next-cycle implication, sampled on the rising edge, off while in reset.
`define FED_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

// File: rtl/core/fed_pkg.sv
package fed_pkg;

	localparam int BUF_DEPTH  = 32768;              // entries per channel, power of two
	localparam int IDX_W      = $clog2(BUF_DEPTH);
	localparam int CHAN_COUNT = 2;
	localparam int CH_W       = 1;
	localparam int MEM_AW     = CH_W + IDX_W;
	localparam int MEM_DEPTH  = CHAN_COUNT * BUF_DEPTH;
	localparam int SAMPLE_W   = 16;
	localparam int GAIN_W     = 16;
	localparam int DELAY_W    = 15;
	localparam int ACC_W      = 2 * SAMPLE_W + 1;   // two Q30 products summed
	localparam int CFG_IDX_W  = 2;

	localparam logic [GAIN_W-1:0]        GAIN_ONE   = 16'h8000;
	localparam logic [GAIN_W-1:0]        FB_RESET   = 16'h4000;
	localparam logic [GAIN_W-1:0]        WET_RESET  = 16'h4000;
	localparam logic [IDX_W-1:0]         DELAY_MAX  = IDX_W'(BUF_DEPTH - 1);
	localparam logic signed [GAIN_W:0]   DRY_COEF   = 17'sd23167;   // 0.707 in Q15

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DELAY    = 2'd0,
		CFG_FEEDBACK = 2'd1,
		CFG_WET      = 2'd2
	} cfg_idx_t;

	// Address info for one word, produced at accept.
	typedef struct packed {
		logic [CH_W-1:0]  ch;
		logic [IDX_W-1:0] widx;
		logic [IDX_W-1:0] ridx;
		logic             filled;   // read entry has been written since reset
	} addr_info_t;

	// Q30 -> Q15, round half up, saturate to the sample range.
	function automatic logic signed [SAMPLE_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W:0] biased;
		logic signed [ACC_W:0] sh;
		logic signed [ACC_W:0] maxv;
		logic signed [ACC_W:0] minv;
		maxv   = (ACC_W+1)'((1 <<< (SAMPLE_W - 1)) - 1);
		minv   = -maxv - 1;
		biased = (ACC_W+1)'(acc) + (ACC_W+1)'(1 <<< (SAMPLE_W - 2));
		sh     = biased >>> (SAMPLE_W - 1);
		if (sh > maxv) begin
			round_sat = maxv[SAMPLE_W-1:0];
		end else if (sh < minv) begin
			round_sat = minv[SAMPLE_W-1:0];
		end else begin
			round_sat = sh[SAMPLE_W-1:0];
		end
	endfunction

	// Unsigned Q15 gain as a signed multiplier operand.
	function automatic logic signed [GAIN_W:0] gain_s(input logic [GAIN_W-1:0] g);
		gain_s = signed'({1'b0, g});
	endfunction

endpackage

// File: rtl/core/fed_addr.sv
module fed_addr (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [fed_pkg::CH_W-1:0]    ch,
	input  logic [fed_pkg::IDX_W-1:0]   delay,
	output fed_pkg::addr_info_t         info
);
	import fed_pkg::*;

	logic [IDX_W-1:0] widx_q [CHAN_COUNT];
	logic             wrap_q [CHAN_COUNT];
	logic [IDX_W-1:0] w;
	logic [IDX_W-1:0] r;

	assign w = widx_q[ch];
	assign r = w - delay;   // wraps mod depth

	// Entries below the write index are written; all of them once wrapped.
	assign info.ch     = ch;
	assign info.widx   = w;
	assign info.ridx   = r;
	assign info.filled = wrap_q[ch] || (r < w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHAN_COUNT; i++) begin
				widx_q[i] <= '0;
				wrap_q[i] <= 1'b0;
			end
		end else if (accept) begin
			widx_q[ch] <= w + IDX_W'(1);
			if (w == DELAY_MAX) begin
				wrap_q[ch] <= 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/feedback_echo_delay.sv
// Channel | Signals                                  | Direction
// --------+------------------------------------------+----------
// input   | in_valid, in_stall, sample_in, channel   | in (stall out)
// output  | out_valid, out_stall, sample_out         | out (stall in)
// config  | cfg_valid, cfg_ready, cfg_index, cfg_data| in (ready out)
//
// One word per cycle sustained while out_stall is low; an accepted word is registered
// in stage 1 and then in the output register, where out_valid goes high for it.
// The delay memory takes one read at accept and one write as the word leaves
// stage 1, so each word uses the memory's read port once and its write port once.
// Reset clears config, write pointers and fill flags; memory contents are not
// cleared but unwritten entries read as zero, so no clearing pass is needed.
// in_stall rises only while stage 1 and the output register are both full and
// out_stall is high.
module feedback_echo_delay (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [fed_pkg::SAMPLE_W-1:0]  sample_in,
	input  logic [fed_pkg::CH_W-1:0]             channel,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [fed_pkg::SAMPLE_W-1:0]  sample_out,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [fed_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [fed_pkg::GAIN_W-1:0]           cfg_data
);
	import fed_pkg::*;

	// ---- configuration registers (gains capped to 1.0 on write) ----
	logic [IDX_W-1:0]  delay_q;
	logic [GAIN_W-1:0] fb_q;
	logic [GAIN_W-1:0] wet_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= '0;
			fb_q    <= FB_RESET;
			wet_q   <= WET_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_DELAY: begin
					if (cfg_data[DELAY_W-1:0] > DELAY_W'(DELAY_MAX)) begin
						delay_q <= DELAY_MAX;
					end else begin
						delay_q <= IDX_W'(cfg_data[DELAY_W-1:0]);
					end
				end
				CFG_FEEDBACK: fb_q  <= (cfg_data > GAIN_ONE) ? GAIN_ONE : cfg_data;
				CFG_WET:      wet_q <= (cfg_data > GAIN_ONE) ? GAIN_ONE : cfg_data;
				default: ;
			endcase
		end
	end

	// ---- handshake ----
	logic valid_s1;
	logic out_valid_q;
	logic adv_s1;
	logic accept;

	assign adv_s1    = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !adv_s1;
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	// ---- stage 0: address generation, memory read, dry products ----
	addr_info_t info;

	fed_addr u_addr (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.ch     (channel),
		.delay  (delay_q),
		.info   (info)
	);

	logic signed [ACC_W-1:0] dry_p;
	logic signed [ACC_W-1:0] dmix_p;

	assign dry_p  = ACC_W'(DRY_COEF * sample_in);
	assign dmix_p = ACC_W'(gain_s(GAIN_ONE - wet_q) * sample_in);

	addr_info_t              info_s1;
	logic signed [ACC_W-1:0] dry_p_s1;
	logic signed [ACC_W-1:0] dmix_p_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1   <= info;
			dry_p_s1  <= dry_p;
			dmix_p_s1 <= dmix_p;
		end
	end

	// ---- delay memory: one read at accept, one write as stage 1 retires ----
	logic signed [SAMPLE_W-1:0] mem [MEM_DEPTH];
	logic signed [SAMPLE_W-1:0] rdata_q;
	logic signed [SAMPLE_W-1:0] wr_val;
	logic [MEM_AW-1:0]          waddr;

	assign waddr = {info_s1.ch, info_s1.widx};

	always_ff @(posedge clk) begin
		if (accept) begin
			rdata_q <= mem[{info.ch, info.ridx}];
		end
		if (adv_s1) begin
			mem[waddr] <= wr_val;
		end
	end

	// Last write, kept for a read that landed on the same edge as that write.
	// Older writes are already in memory, so matching them is harmless.
	logic                       lw_valid_q;
	logic [MEM_AW-1:0]          lw_addr_q;
	logic signed [SAMPLE_W-1:0] lw_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_valid_q <= 1'b0;
		end else if (adv_s1) begin
			lw_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			lw_addr_q <= waddr;
			lw_data_q <= wr_val;
		end
	end

	// ---- stage 1: pick delayed value, feedback and wet products ----
	logic                       fwd_hit;
	logic signed [SAMPLE_W-1:0] v;
	logic signed [SAMPLE_W-1:0] mix_val;

	assign fwd_hit = lw_valid_q && (lw_addr_q == {info_s1.ch, info_s1.ridx});

	always_comb begin
		if (!info_s1.filled) begin
			v = '0;                 // never written since reset
		end else if (fwd_hit) begin
			v = lw_data_q;
		end else begin
			v = rdata_q;
		end
	end

	assign wr_val  = round_sat(dry_p_s1 + ACC_W'(gain_s(fb_q) * v));
	assign mix_val = round_sat(dmix_p_s1 + ACC_W'(gain_s(wet_q) * v));

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			sample_out <= mix_val;
		end
	end

endmodule

// File: rtl/core/fed_check.sv
`include "assert_macros.svh"

module fed_check (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_stall,
	input logic                                 out_valid,
	input logic                                 out_stall,
	input logic signed [fed_pkg::SAMPLE_W-1:0]  sample_out
);
	import fed_pkg::*;

	// A stalled output word stays put.
	`FED_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`FED_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(sample_out))

	// Backpressure only reaches the input when the output is full and stalled.
	`FED_ASSERT_NOW(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall)

	// A rising out_valid traces back to an input word accepted earlier, via stage 1.
	`FED_ASSERT_NOW(a_out_origin, clk, arst_n, $rose(out_valid), $past(in_valid && !in_stall, 2))

endmodule

bind feedback_echo_delay fed_check u_fed_check (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.sample_out (sample_out)
);

// File: tb/sv/feedback_echo_delay_tb.sv
module feedback_echo_delay_tb;
	import fed_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 7;
	localparam int MAX_WAIT     = 12;       // longest idle/stall drawn per word
	localparam int HOLD_CYCLES  = 60;       // long sink hold-off, fills the pipe
	localparam int RANDOM_WORDS = 525;
	localparam int DRAIN_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 6;        // lets the pipe settle, plus margin
	localparam int PRINT_LIMIT  = 40;
	localparam int DIR_ROWS     = 25;

	localparam longint DRY_Q15   = 23167;   // 0.707
	localparam longint UNITY_Q15 = 32768;   // 1.0

	typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

	// One directed step: either a register write or a word. Pinned rows carry
	// an expected output that follows from the settings by hand.
	typedef struct packed {
		row_kind_t           kind;
		cfg_idx_t            sel;
		logic [GAIN_W-1:0]   value;
		logic [CH_W-1:0]     ch;
		logic                pinned;
		logic [SAMPLE_W-1:0] pinned_out;
	} dir_row_t;

	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		// reset settings: empty lines, half wet, so each word comes out halved
		'{ROW_WORD, CFG_DELAY,    16'h7FFF, 1'b0, 1'b1, 16'h4000},
		'{ROW_WORD, CFG_DELAY,    16'h8000, 1'b1, 1'b1, 16'hC000},
		'{ROW_WORD, CFG_DELAY,    16'h0001, 1'b0, 1'b1, 16'h0001},  // +0.5 lsb rounds up
		'{ROW_WORD, CFG_DELAY,    16'hFFFF, 1'b1, 1'b1, 16'h0000},  // -0.5 lsb rounds up
		'{ROW_WORD, CFG_DELAY,    16'h0000, 1'b0, 1'b1, 16'h0000},
		// unity feedback, one-sample echo, fully wet: the lines saturate
		'{ROW_REG,  CFG_FEEDBACK, 16'h8000, 1'b0, 1'b0, 16'h0000},
		'{ROW_REG,  CFG_DELAY,    16'h0001, 1'b0, 1'b0, 16'h0000},
		'{ROW_REG,  CFG_WET,      16'h8000, 1'b0, 1'b0, 16'h0000},
		'{ROW_WORD, CFG_DELAY,    16'h7FFF, 1'b0, 1'b0, 16'h0000},
		'{ROW_WORD, CFG_DELAY,    16'h7FFF, 1'b0, 1'b0, 16'h0000},
		'{ROW_WORD, CFG_DELAY,    16'h7FFF, 1'b0, 1'b0, 16'h0000},
		'{ROW_WORD, CFG_DELAY,    16'h8000, 1'b1, 1'b0, 16'h0000},
		'{ROW_WORD, CFG_DELAY,    16'h8000, 1'b1, 1'b0, 16'h0000},
		'{ROW_WORD, CFG_DELAY,    16'h8000, 1'b1, 1'b0, 16'h0000},
		// gains above unity clamp; longest delay, top data bit dropped
		'{ROW_REG,  CFG_FEEDBACK, 16'hFFFF, 1'b0, 1'b0, 16'h0000},
		'{ROW_REG,  CFG_WET,      16'hFFFF, 1'b0, 1'b0, 16'h0000},
		'{ROW_REG,  CFG_DELAY,    16'hFFFF, 1'b0, 1'b0, 16'h0000},
		'{ROW_WORD, CFG_DELAY,    16'h3039, 1'b0, 1'b0, 16'h0000},
		'{ROW_WORD, CFG_DELAY,    16'hEF1F, 1'b1, 1'b0, 16'h0000},
		// fully dry, zero delay: the word passes unchanged
		'{ROW_REG,  CFG_WET,      16'h0000, 1'b0, 1'b0, 16'h0000},
		'{ROW_REG,  CFG_FEEDBACK, 16'h0000, 1'b0, 1'b0, 16'h0000},
		'{ROW_REG,  CFG_DELAY,    16'h0000, 1'b0, 1'b0, 16'h0000},
		'{ROW_WORD, CFG_DELAY,    16'h7FFF, 1'b0, 1'b1, 16'h7FFF},
		'{ROW_WORD, CFG_DELAY,    16'h8000, 1'b1, 1'b1, 16'h8000},
		'{ROW_WORD, CFG_DELAY,    16'h5555, 1'b0, 1'b1, 16'h5555}
	};

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       in_valid  = 1'b0;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample_in = '0;
	logic [CH_W-1:0]            channel   = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [GAIN_W-1:0]          cfg_data  = '0;

	// Model state: one circular line and write head per channel, plus settings.
	logic signed [SAMPLE_W-1:0] echo_line [CHAN_COUNT][BUF_DEPTH];
	logic [IDX_W-1:0]           head [CHAN_COUNT];
	logic [DELAY_W-1:0]         delay_len = '0;
	logic [GAIN_W-1:0]          fb_gain   = 16'd16384;
	logic [GAIN_W-1:0]          wet_gain  = 16'd16384;

	logic signed [SAMPLE_W-1:0] due_samples [$];   // expected output words, oldest first
	int                         mismatch_count = 0;

	// Pacing knobs shared between the source, the sink and the sequence.
	bit tx_quiet     = 1'b0;   // source offers back to back
	bit rx_quiet     = 1'b0;   // sink never stalls
	bit hold_pending = 1'b0;   // sink does one long hold-off at its next word

	feedback_echo_delay uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_in  (sample_in),
		.channel    (channel),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Lines are all zero after reset.
	initial begin
		foreach (echo_line[c, i]) echo_line[c][i] = '0;
		foreach (head[c]) head[c] = '0;
	end

	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT) begin
			$display("%0t: MISMATCH %s", $time, what);
		end
	endtask

	// Q30 sum -> Q15, round half up, clip to the sample range.
	function automatic logic signed [SAMPLE_W-1:0] q30_to_q15(input longint acc);
		longint r;
		r = (acc + 16384) >>> 15;
		if (r > 32767) begin
			r = 32767;
		end else if (r < -32768) begin
			r = -32768;
		end
		return r[SAMPLE_W-1:0];
	endfunction

	function automatic longint unity_cap(input logic [GAIN_W-1:0] g);
		return (g > 16'h8000) ? UNITY_Q15 : longint'(g);
	endfunction

	// Tap the line, write the feedback sum at the head, advance the head,
	// and return the dry/wet mix.
	function automatic logic signed [SAMPLE_W-1:0] echo_predict(
			input logic signed [SAMPLE_W-1:0] x, input logic [CH_W-1:0] ch);
		longint           dry;
		longint           tap;
		longint           fb;
		longint           wet;
		logic [IDX_W-1:0] wr;
		logic [IDX_W-1:0] rd;
		dry = x;
		wr  = head[ch];
		rd  = wr - delay_len;   // zero delay taps the head itself: a full-line echo
		tap = echo_line[ch][rd];
		fb  = unity_cap(fb_gain);
		wet = unity_cap(wet_gain);
		echo_line[ch][wr] = q30_to_q15(DRY_Q15 * dry + fb * tap);
		head[ch] = wr + 1'b1;
		return q30_to_q15((UNITY_Q15 - wet) * dry + wet * tap);
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 16'h8000;
			2: return 16'hFFFF;
			5: return 16'($urandom);
			default: return 16'($urandom_range(0, 32768));
		endcase
	endfunction

	// Mostly short delays so echoes land inside one burst.
	function automatic logic [GAIN_W-1:0] pick_delay();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 16'hFFFF;
			2: return 16'($urandom);
			default: return 16'($urandom_range(1, 24));
		endcase
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'($urandom_range(0, 31)) - 16'd16;
			default: return 16'($urandom);
		endcase
	endfunction

	// Register write. cfg_valid is left high so writes can go back to back;
	// the next word or drain drops it.
	task automatic write_reg(input cfg_idx_t sel, input logic [GAIN_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (sel)
			CFG_DELAY:    delay_len = value[DELAY_W-1:0];
			CFG_FEEDBACK: fb_gain   = value;
			CFG_WET:      wet_gain  = value;
			default: ;
		endcase
	endtask

	// Offer one word after a random gap and hold it until taken. valid stays
	// up across back-to-back words; it only drops when a gap is drawn or a drain starts.
	task automatic send_word(input logic signed [SAMPLE_W-1:0] x, input logic [CH_W-1:0] ch,
			input bit pinned, input logic signed [SAMPLE_W-1:0] pinned_out);
		int                         gap;
		logic signed [SAMPLE_W-1:0] want;
		gap = tx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
		cfg_valid <= 1'b0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		sample_in <= x;
		channel   <= ch;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		want = echo_predict(x, ch);
		due_samples.push_back(pinned ? pinned_out : want);
	endtask

	// Stop offering, let every expected word come back, then let the pipe settle.
	task automatic wait_idle();
		in_valid  <= 1'b0;
		cfg_valid <= 1'b0;
		for (int i = 0; i < DRAIN_LIMIT && due_samples.size() != 0; i++) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Sink: draws a stall per word, or the long hold-off when one is pending.
	initial begin
		int pause;
		@(posedge clk);
		forever begin
			if (hold_pending) begin
				pause = HOLD_CYCLES;
				hold_pending = 1'b0;
			end else begin
				pause = rx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
			end
			if (pause > 0) begin
				out_stall <= 1'b1;
				repeat (pause) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// Output check: every taken word against the oldest expectation.
	always @(posedge clk) begin
		logic signed [SAMPLE_W-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_samples.size() == 0) begin
				report_mismatch($sformatf("word %0d with nothing expected", sample_out));
			end else begin
				want = due_samples.pop_front();
				if (sample_out !== want) begin
					report_mismatch($sformatf("sample_out %0d, expected %0d", sample_out, want));
				end
			end
		end
	end

	initial begin
		dir_row_t        row;
		bit              in_reg_burst;
		bit              ch_lock;
		logic [CH_W-1:0] lock_ch;
		int              words_sent;
		int              burst;
		int              phase;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows; a run of register writes starts from an idle block.
		in_reg_burst = 1'b0;
		for (int i = 0; i < DIR_ROWS; i++) begin
			row = DIRECTED[i];
			if (row.kind == ROW_REG) begin
				if (!in_reg_burst) wait_idle();
				write_reg(row.sel, row.value);
				in_reg_burst = 1'b1;
			end else begin
				send_word(row.value, row.ch, row.pinned, row.pinned_out);
				in_reg_burst = 1'b0;
			end
		end

		// Random phases: fresh settings, then a burst of words. Every fourth
		// phase the sink holds off long while the source streams, so the block
		// fills and pushes back on its input.
		words_sent = 0;
		phase = 0;
		while (words_sent < RANDOM_WORDS) begin
			wait_idle();
			write_reg(CFG_DELAY, pick_delay());
			write_reg(CFG_FEEDBACK, pick_gain());
			write_reg(CFG_WET, pick_gain());
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			ch_lock  = ($urandom_range(0, 2) == 0);
			lock_ch  = CH_W'($urandom);
			if (phase % 4 == 1) begin
				hold_pending = 1'b1;
				tx_quiet = 1'b1;
			end
			burst = $urandom_range(20, 70);
			repeat (burst) begin
				send_word(pick_sample(), ch_lock ? lock_ch : CH_W'($urandom), 1'b0, '0);
				words_sent++;
			end
			phase++;
		end

		wait_idle();
		if (due_samples.size() != 0) begin
			report_mismatch($sformatf("%0d expected words never came out", due_samples.size()));
		end
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
